// ----- hw/rtl/lsal_pkg.sv -----
// Shared widths, constants and arithmetic helpers for the light sample averager.
package lsal_pkg;

  localparam int unsigned SAMPLE_W        = 12;
  localparam int unsigned MV_W            = 12;
  localparam int unsigned LUX_W           = 17;
  localparam int unsigned BAND_W          = 3;
  localparam int unsigned SAMPLES_DEFAULT = 16;
  localparam int unsigned MAX_SAMPLE      = 4095;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MV_W-1:0]     mv_t;
  typedef logic [LUX_W-1:0]    lux_t;
  typedef logic [BAND_W-1:0]   band_t;

  localparam sample_t DARK_LIMIT = 12'd124;

  // 100000 / 4095 = 24 remainder 1720
  localparam logic [4:0]  LUX_WHOLE = 5'd24;
  localparam logic [10:0] LUX_FRAC  = 11'd1720;
  localparam logic [11:0] MV_SCALE  = 12'd3300;

  localparam lux_t LUX_DIM    = 17'd100;
  localparam lux_t LUX_INDOOR = 17'd1000;
  localparam lux_t LUX_CLOUDY = 17'd10000;
  localparam lux_t LUX_SUNNY  = 17'd100000;

  localparam band_t BAND_DARK   = 3'd0;
  localparam band_t BAND_DIM    = 3'd1;
  localparam band_t BAND_INDOOR = 3'd2;
  localparam band_t BAND_CLOUDY = 3'd3;
  localparam band_t BAND_SUNNY  = 3'd4;

  // floor(x / 4095), exact for x < 4095 * 4096
  function automatic logic [12:0] div_4095(input logic [23:0] x);
    logic [24:0] t;
    t = {1'b0, x} + {13'd0, x[23:12]} + 25'd1;
    return t[24:12];
  endfunction

  function automatic lux_t lux_of(input sample_t s);
    logic [22:0] frac_prod;
    logic [12:0] frac;
    lux_t        whole;
    frac_prod = 23'(s) * 23'(LUX_FRAC);
    frac      = div_4095({1'b0, frac_prod});
    whole     = LUX_W'(s) * LUX_W'(LUX_WHOLE);
    if (s <= DARK_LIMIT) begin
      return '0;
    end
    return whole + LUX_W'(frac);
  endfunction

  function automatic mv_t mv_of(input sample_t avg);
    logic [23:0] prod;
    logic [12:0] q;
    prod = 24'(avg) * 24'(MV_SCALE);
    q    = div_4095(prod);
    return q[MV_W-1:0];
  endfunction

  function automatic band_t band_of(input lux_t lux);
    priority if (lux < LUX_DIM) begin
      return BAND_DARK;
    end else if (lux < LUX_INDOOR) begin
      return BAND_DIM;
    end else if (lux < LUX_CLOUDY) begin
      return BAND_INDOOR;
    end else if (lux < LUX_SUNNY) begin
      return BAND_CLOUDY;
    end else begin
      return BAND_SUNNY;
    end
  endfunction

endpackage

// ----- hw/rtl/light_sample_average_lux.sv -----
// Light sample averager: ring window, running sum, millivolt average and lux band.
//
// Input channel: sample with in_valid / in_ready; a transfer happens on a rising
// edge with both high. Output channel: raw_echo, avg_millivolts, lux_centi and
// light_band with out_valid / out_ready, one result per accepted sample.
// A transfer writes the sample into a SAMPLES-entry ring, replacing the oldest
// entry, and updates the running window sum in the same cycle.
// A result passes the ring/sum stage and then the result register before it
// shows on out_valid.
// Throughput: one sample per clock unless out_ready stalls the output; the
// oldest ring entry is read ahead, so the ring port never limits the rate.
// Reset: the window reads as all zero, the write slot returns to entry 0 and
// both stages empty. A fill flag masks ring entries not yet written.
// Stall: when out_ready is low, results hold in the result register and the
// stage behind it fills; in_ready drops once both stages hold an item.
module light_sample_average_lux #(
  parameter int unsigned SAMPLES = lsal_pkg::SAMPLES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lsal_pkg::SAMPLE_W-1:0]  sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lsal_pkg::SAMPLE_W-1:0]  raw_echo,
  output logic [lsal_pkg::MV_W-1:0]      avg_millivolts,
  output logic [lsal_pkg::LUX_W-1:0]     lux_centi,
  output logic [lsal_pkg::BAND_W-1:0]    light_band
);

  localparam int unsigned SLOT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned TOT_W    = $clog2(SAMPLES * lsal_pkg::MAX_SAMPLE + 1);
  localparam int unsigned DIV_SH   = TOT_W + $clog2(SAMPLES);
  localparam longint unsigned DIV_M = ((64'd1 << DIV_SH) + SAMPLES - 1) / SAMPLES;
  localparam int unsigned DIV_M_W  = $clog2(DIV_M + 1);
  localparam int unsigned PROD_W   = TOT_W + DIV_M_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLES - 1);
  localparam logic [TOT_W-1:0]  MAX_TOTAL = TOT_W'(SAMPLES * lsal_pkg::MAX_SAMPLE);

  lsal_pkg::sample_t ring [SAMPLES];
  lsal_pkg::sample_t oldest;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [SLOT_W-1:0] rd_addr;
  logic              full;
  logic [TOT_W-1:0]  window_total;
  logic [TOT_W-1:0]  window_total_next;
  lsal_pkg::sample_t drop_value;

  logic              a_valid;
  lsal_pkg::sample_t a_sample;
  lsal_pkg::sample_t a_avg;
  lsal_pkg::lux_t    a_lux;

  logic              accept;
  logic              adv_c;
  logic [PROD_W-1:0] avg_prod;

  assign adv_c    = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || adv_c;
  assign accept   = in_valid && in_ready;

  assign slot_next  = (slot == LAST_SLOT) ? '0 : slot + SLOT_W'(1);
  assign rd_addr    = accept ? slot_next : slot;
  assign drop_value = full ? oldest : '0;
  assign window_total_next = window_total - TOT_W'(drop_value) + TOT_W'(sample);

  // ring write and look-ahead read of the entry to drop next
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[slot] <= sample;
    end
    if (accept && (slot_next == slot)) begin
      oldest <= sample;
    end else begin
      oldest <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot         <= '0;
      full         <= 1'b0;
      window_total <= '0;
      a_valid      <= 1'b0;
    end else begin
      if (accept) begin
        slot         <= slot_next;
        window_total <= window_total_next;
        if (slot == LAST_SLOT) begin
          full <= 1'b1;
        end
      end
      if (accept) begin
        a_valid <= 1'b1;
      end else if (adv_c) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample <= sample;
    end
  end

  assign avg_prod = PROD_W'(window_total) * PROD_W'(DIV_M);
  assign a_avg    = lsal_pkg::SAMPLE_W'(avg_prod >> DIV_SH);
  assign a_lux    = lsal_pkg::lux_of(a_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_c) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      raw_echo       <= a_sample;
      avg_millivolts <= lsal_pkg::mv_of(a_avg);
      lux_centi      <= a_lux;
      light_band     <= lsal_pkg::band_of(a_lux);
    end
  end

  a_full_sticky : assert property (@(posedge clk) disable iff (rst) full |=> full)
    else $error("fill flag dropped");

  a_total_bound : assert property (@(posedge clk) disable iff (rst)
    window_total <= MAX_TOTAL)
    else $error("window sum out of range");

  a_slot_range : assert property (@(posedge clk) disable iff (rst) slot <= LAST_SLOT)
    else $error("write slot out of range");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (a_valid && out_valid && !out_ready))
    else $error("input stalled with room in the pipeline");

endmodule
